// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted (active-low reset).
`define PSCC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PSCC_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pscc_pkg.sv =====
package pscc_pkg;

    // Rows per page; must be a power of two.
    localparam int PAGE_ROWS  = 256;
    localparam int PAGE_SHIFT = $clog2(PAGE_ROWS);

    localparam int CAP_W   = 20;
    localparam int ROWS_W  = 48;                 // running row total, wraps
    localparam int START_W = 32 + PAGE_SHIFT;    // slot * PAGE_ROWS
    localparam int LIMIT_W = CAP_W + PAGE_SHIFT; // capacity * PAGE_ROWS
    localparam int SUM_W   = ROWS_W + 1;

    // Commands
    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_PAGE   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Reason codes
    localparam logic [3:0] RSN_OK          = 4'd0;
    localparam logic [3:0] RSN_DISABLED    = 4'd1;
    localparam logic [3:0] RSN_CONTRACT    = 4'd2;
    localparam logic [3:0] RSN_EMPTY       = 4'd3;
    localparam logic [3:0] RSN_NO_QUERIES  = 4'd4;
    localparam logic [3:0] RSN_QUERY_ORDER = 4'd5;
    localparam logic [3:0] RSN_BAD_PAGE    = 4'd6;
    localparam logic [3:0] RSN_NONCONTIG   = 4'd7;
    localparam logic [3:0] RSN_PARTIAL     = 4'd8;
    localparam logic [3:0] RSN_OVERFLOW    = 4'd9;

    // Register indexes (word address)
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_CONTRACT = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;
    localparam logic [1:0] REG_EXPECTED = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] query_position;
        logic [31:0]        lpage_num;
        logic [31:0]        physical_slot;
        logic [15:0]        page_rows;
        logic signed [31:0] native_begin;
        logic signed [31:0] native_end;
    } t_in_item;

    typedef struct packed {
        logic        eligible;
        logic [3:0]  reason_code;
        logic [31:0] first_row;
        logic [31:0] span_rows;
    } t_out_item;

    typedef struct packed {
        logic              mode_enabled;
        logic              contract_met;
        logic [CAP_W-1:0]  physical_page_capacity;
        logic [31:0]       expected_rows;
    } t_cfg;

endpackage

// ===== design/paged_span_contiguity_check_unit.sv =====
// Channel   | Valid        | Stall        | Payload
// ----------+--------------+--------------+-------------------------
// input     | i_in_valid   | o_in_stall   | i_in_item  (t_in_item)
// output    | o_out_valid  | i_out_stall  | o_out_item (t_out_item)
// config    | APB write: psel & penable & pwrite & pready, regs at 4*i
//
// An accepted item is held in the input register; from there it updates the span
// state or, for a finish, loads the result register.
// One item per cycle sustained; a finish item stalls only while the previous
// result is held in the result register by i_out_stall, so o_in_stall follows
// i_out_stall combinationally in that one case.
// Reset (synchronous, active low) clears the config registers, the span state
// and both valid flags; no clearing pass is needed.

module paged_span_contiguity_check_unit
    import pscc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg w_cfg;

    // mode, contract, capacity and expected row count
    pscc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // page checks, running span state, finish report
    pscc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== design/pscc_cfg.sv =====
`include "assert_macros.svh"

module pscc_cfg
    import pscc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_idx  = paddr[3:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_MODE:     r_cfg.mode_enabled           <= pwdata[0];
                REG_CONTRACT: r_cfg.contract_met           <= pwdata[0];
                REG_CAPACITY: r_cfg.physical_page_capacity <= pwdata[CAP_W-1:0];
                REG_EXPECTED: r_cfg.expected_rows          <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MODE:     prdata = {31'b0, r_cfg.mode_enabled};
            REG_CONTRACT: prdata = {31'b0, r_cfg.contract_met};
            REG_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, r_cfg.physical_page_capacity};
            REG_EXPECTED: prdata = r_cfg.expected_rows;
            default:      prdata = '0;
        endcase
    end

    `PSCC_ASSERT(a_cap_write, i_clk, i_rst_n,
        (w_wr && w_idx == REG_CAPACITY) |=>
            (r_cfg.physical_page_capacity == $past(pwdata[CAP_W-1:0])),
        "capacity write lost")
    `PSCC_ASSERT(a_mode_write, i_clk, i_rst_n,
        (w_wr && w_idx == REG_MODE) |=> (r_cfg.mode_enabled == $past(pwdata[0])),
        "mode write lost")
    `PSCC_ASSERT_ALWAYS(a_pready_high, i_clk, pready, "pready dropped")

endmodule

// ===== design/pscc_core.sv =====
`include "assert_macros.svh"

module pscc_core
    import pscc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // input register
    logic     r_in_vld;
    t_in_item r_in;

    // running state
    logic                r_queries_seen;
    logic signed [31:0]  r_last_query;
    logic                r_query_disorder;
    logic                r_pages_seen;
    logic signed [31:0]  r_prev_end;
    logic [31:0]         r_prev_logical;
    logic [31:0]         r_prev_slot;
    logic                r_prev_full;
    logic [3:0]          r_page_err;
    logic [START_W-1:0]  r_span_start;
    logic [ROWS_W-1:0]   r_rows_total;

    // result register
    logic      r_out_vld;
    t_out_item r_out;

    logic      w_go, w_is_finish, w_fin_go, w_page_go, w_query_go;
    logic      w_bad, w_discont, w_full;
    logic [3:0] n_page_err, w_reason;
    logic signed [32:0] w_end_calc;
    logic [SUM_W-1:0]   w_span_sum, w_limit;
    t_out_item n_out;

    // A finish waits while the result register holds a result the receiver stalls.
    assign w_is_finish = r_in.command == CMD_FINISH;
    assign o_in_stall  = r_in_vld & w_is_finish & r_out_vld & i_out_stall;
    assign w_go        = r_in_vld & ~o_in_stall;
    assign w_fin_go    = w_go & w_is_finish;
    assign w_page_go   = w_go & (r_in.command == CMD_PAGE);
    assign w_query_go  = w_go & (r_in.command == CMD_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // page checks
    assign w_end_calc = 33'(r_in.native_begin) + $signed({17'b0, r_in.page_rows});
    assign w_full     = {1'b0, r_in.page_rows} == 17'(PAGE_ROWS);
    assign w_bad = (r_in.page_rows == '0)
                || ({1'b0, r_in.page_rows} > 17'(PAGE_ROWS))
                || (r_in.physical_slot >= {{(32-CAP_W){1'b0}}, i_cfg.physical_page_capacity})
                || r_in.native_begin[31]
                || (33'(r_in.native_end) != w_end_calc)
                || (r_in.native_begin[PAGE_SHIFT-1:0] != '0);
    assign w_discont = (r_in.lpage_num != r_prev_logical + 32'd1)
                    || (r_in.physical_slot != r_prev_slot + 32'd1)
                    || (r_in.native_begin != r_prev_end);

    // first error in stream order; partial-not-tail is noted before this page's checks
    always_comb begin
        n_page_err = r_page_err;
        if (r_pages_seen && !r_prev_full && n_page_err == '0) begin
            n_page_err = RSN_PARTIAL;
        end
        if (n_page_err == '0) begin
            if (w_bad) begin
                n_page_err = RSN_BAD_PAGE;
            end else if (r_pages_seen && w_discont) begin
                n_page_err = RSN_NONCONTIG;
            end
        end
    end

    // finish
    assign w_span_sum = SUM_W'(r_span_start) + SUM_W'(r_rows_total);
    assign w_limit    = SUM_W'({i_cfg.physical_page_capacity, {PAGE_SHIFT{1'b0}}});

    always_comb begin
        if (!i_cfg.mode_enabled) begin
            w_reason = RSN_DISABLED;
        end else if (!i_cfg.contract_met) begin
            w_reason = RSN_CONTRACT;
        end else if (i_cfg.physical_page_capacity == '0 || !r_pages_seen) begin
            w_reason = RSN_EMPTY;
        end else if (!r_queries_seen) begin
            w_reason = RSN_NO_QUERIES;
        end else if (r_query_disorder) begin
            w_reason = RSN_QUERY_ORDER;
        end else if (r_page_err != '0) begin
            w_reason = r_page_err;
        end else if (r_span_start[START_W-1:32] != '0 || r_rows_total == '0
                     || r_rows_total != ROWS_W'(i_cfg.expected_rows)
                     || w_span_sum > w_limit) begin
            w_reason = RSN_OVERFLOW;
        end else begin
            w_reason = RSN_OK;
        end
    end

    always_comb begin
        n_out.eligible    = w_reason == RSN_OK;
        n_out.reason_code = w_reason;
        n_out.first_row   = n_out.eligible ? r_span_start[31:0] : 32'd0;
        n_out.span_rows   = n_out.eligible ? r_rows_total[31:0] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_fin_go) begin
            r_queries_seen   <= 1'b0;
            r_last_query     <= '0;
            r_query_disorder <= 1'b0;
            r_pages_seen     <= 1'b0;
            r_prev_end       <= -32'sd1;
            r_prev_logical   <= '1;
            r_prev_slot      <= '1;
            r_prev_full      <= 1'b1;
            r_page_err       <= '0;
            r_span_start     <= '0;
            r_rows_total     <= '0;
        end else if (w_query_go) begin
            if (r_queries_seen && r_in.query_position < r_last_query) begin
                r_query_disorder <= 1'b1;
            end
            r_last_query   <= r_in.query_position;
            r_queries_seen <= 1'b1;
        end else if (w_page_go) begin
            if (!r_pages_seen) begin
                r_span_start <= {r_in.physical_slot, {PAGE_SHIFT{1'b0}}};
            end
            r_page_err     <= n_page_err;
            r_prev_end     <= r_in.native_end;
            r_prev_logical <= r_in.lpage_num;
            r_prev_slot    <= r_in.physical_slot;
            r_prev_full    <= w_full;
            r_rows_total   <= r_rows_total + ROWS_W'(r_in.page_rows);
            r_pages_seen   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fin_go) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    `PSCC_ASSERT(a_fin_result, i_clk, i_rst_n, w_fin_go |=> r_out_vld,
        "finish gave no result")
    `PSCC_ASSERT(a_fin_clear, i_clk, i_rst_n,
        w_fin_go |=> (!r_pages_seen && !r_queries_seen && r_page_err == '0),
        "finish left state behind")
    `PSCC_ASSERT(a_fail_zero, i_clk, i_rst_n,
        (r_out_vld && !r_out.eligible) |->
            (r_out.span_rows == '0 && r_out.first_row == '0 && r_out.reason_code != RSN_OK),
        "failed result carries span")

endmodule

// ===== tb/sv/tb_paged_span_contiguity_check_unit.sv =====
module tb_paged_span_contiguity_check_unit;
    import pscc_pkg::*;

    // Command 3 has no name in the package; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with nothing moving
    localparam int HOLD_CYCLES    = 120;   // long receiver hold-off
    localparam int DRAIN_CYCLES   = 4;     // two-stage pipe plus slack

    // Predicted span state, one copy per stream of items up to a finish.
    typedef struct {
        bit                 seen_query;
        logic signed [31:0] last_query;
        bit                 query_disorder;
        bit                 seen_page;
        logic signed [31:0] end_prev;
        logic [31:0]        logical_prev;
        logic [31:0]        slot_prev;
        bit                 full_prev;
        logic [3:0]         page_error;
        logic [47:0]        row_start;
        logic [47:0]        row_total;
    } t_span_track;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copy as the block should hold it.
    t_cfg        cfg = '0;
    t_span_track span;
    t_out_item   expected_reports[$];

    int          errors = 0;
    int          items_sent = 0;
    int          reports_checked = 0;
    int          writes_done = 0;
    logic [15:0] reasons_seen = '0;

    // Sender burst control.
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    bit          offering = 1'b0;

    // Random span shape, kept until the next register change so that
    // expected_rows keeps matching most spans.
    int          plan_pages = 1;
    int          plan_tail = PAGE_ROWS;

    // Receiver stall pattern.
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          mode_left = 0;
    int          stall_mode = 0;
    int          holds_done = 0;

    t_out_item   report_want;

    paged_span_contiguity_check_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_span_track span_cleared();
        t_span_track s;
        s.seen_query     = 1'b0;
        s.last_query     = '0;
        s.query_disorder = 1'b0;
        s.seen_page      = 1'b0;
        s.end_prev       = -32'sd1;
        s.logical_prev   = '1;
        s.slot_prev      = '1;
        s.full_prev      = 1'b1;
        s.page_error     = RSN_OK;   // RSN_OK doubles as "no page error yet"
        s.row_start      = '0;
        s.row_total      = '0;
        return s;
    endfunction

    // Only the first page error in stream order sticks.
    function automatic void flag_page_error(input logic [3:0] code);
        if (span.page_error == RSN_OK) begin
            span.page_error = code;
        end
    endfunction

    function automatic logic [3:0] span_verdict();
        longint unsigned row_limit = longint'(cfg.physical_page_capacity) << PAGE_SHIFT;
        if (!cfg.mode_enabled) return RSN_DISABLED;
        if (!cfg.contract_met) return RSN_CONTRACT;
        if (cfg.physical_page_capacity == 0 || !span.seen_page) return RSN_EMPTY;
        if (!span.seen_query) return RSN_NO_QUERIES;
        if (span.query_disorder) return RSN_QUERY_ORDER;
        if (span.page_error != RSN_OK) return span.page_error;
        if (span.row_start > 48'hFFFF_FFFF || span.row_total == 0 ||
            span.row_total != 48'(cfg.expected_rows) ||
            64'(span.row_start) + 64'(span.row_total) > row_limit) return RSN_OVERFLOW;
        return RSN_OK;
    endfunction

    // Advance the predicted state by one accepted item; a finish queues a report.
    function automatic void track_span_item(input t_in_item it);
        longint          nb;
        longint          ne;
        longint unsigned rows;
        logic [3:0]      verdict;
        bit              bad;
        t_out_item       rpt;
        case (it.command)
            CMD_QUERY: begin
                if (span.seen_query && $signed(it.query_position) < span.last_query) begin
                    span.query_disorder = 1'b1;
                end
                span.last_query = it.query_position;
                span.seen_query = 1'b1;
            end
            CMD_PAGE: begin
                nb   = $signed(it.native_begin);
                ne   = $signed(it.native_end);
                rows = it.page_rows;
                // A partial page is caught when the next one shows up.
                if (span.seen_page && !span.full_prev) begin
                    flag_page_error(RSN_PARTIAL);
                end
                bad = rows == 0 || rows > PAGE_ROWS ||
                      it.physical_slot >= 32'(cfg.physical_page_capacity) ||
                      nb < 0 || ne != nb + longint'(rows) || nb % PAGE_ROWS != 0;
                if (bad) begin
                    flag_page_error(RSN_BAD_PAGE);
                end else if (span.seen_page &&
                             (it.lpage_num != span.logical_prev + 32'd1 ||
                              it.physical_slot != span.slot_prev + 32'd1 ||
                              nb != longint'(span.end_prev))) begin
                    flag_page_error(RSN_NONCONTIG);
                end
                if (!span.seen_page) begin
                    span.row_start = 48'(it.physical_slot) << PAGE_SHIFT;
                end
                span.end_prev     = it.native_end;
                span.logical_prev = it.lpage_num;
                span.slot_prev    = it.physical_slot;
                span.full_prev    = (rows == PAGE_ROWS);
                span.row_total    = span.row_total + 48'(it.page_rows);
                span.seen_page    = 1'b1;
            end
            CMD_FINISH: begin
                verdict         = span_verdict();
                rpt.eligible    = (verdict == RSN_OK);
                rpt.reason_code = verdict;
                rpt.first_row   = (verdict == RSN_OK) ? span.row_start[31:0] : 32'd0;
                rpt.span_rows   = (verdict == RSN_OK) ? span.row_total[31:0] : 32'd0;
                expected_reports.push_back(rpt);
                span = span_cleared();
            end
            default: ;  // unused command: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item builders; unused fields carry random junk on purpose.
    // ------------------------------------------------------------------

    function automatic t_in_item random_item();
        t_in_item it;
        it.command        = 2'($urandom);
        it.query_position = $urandom;
        it.lpage_num      = $urandom;
        it.physical_slot  = $urandom;
        it.page_rows      = 16'($urandom);
        it.native_begin   = $urandom;
        it.native_end     = $urandom;
        return it;
    endfunction

    function automatic t_in_item query_item(input logic signed [31:0] pos);
        t_in_item it = random_item();
        it.command        = CMD_QUERY;
        it.query_position = pos;
        return it;
    endfunction

    function automatic t_in_item page_item(input logic [31:0] logical, input logic [31:0] slot,
                                           input logic [15:0] rows, input logic [31:0] nb);
        t_in_item it = random_item();
        it.command       = CMD_PAGE;
        it.lpage_num     = logical;
        it.physical_slot = slot;
        it.page_rows     = rows;
        it.native_begin  = nb;
        it.native_end    = nb + 32'(rows);
        return it;
    endfunction

    function automatic t_in_item finish_item();
        t_in_item it = random_item();
        it.command = CMD_FINISH;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one item, hold it until accepted, then maybe open a gap.
    task automatic send_item(input t_in_item it);
        int gap;
        in_item  <= it;
        in_valid <= 1'b1;
        offering = 1'b1;
        do @(posedge i_clk); while (in_stall);
        track_span_item(it);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering, wait for every report, then let the pipe empty.
    task automatic drain_block();
        if (offering) begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup phase, access phase, then an idle phase with psel low, so back-to-back writes
    // never lower and raise psel in the same step.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MODE:     cfg.mode_enabled           = value[0];
            REG_CONTRACT: cfg.contract_met           = value[0];
            REG_CAPACITY: cfg.physical_page_capacity = value[CAP_W-1:0];
            REG_EXPECTED: cfg.expected_rows          = value;
            default: ;
        endcase
        writes_done++;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall modes, plus one long hold-off on request.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 80);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= 1'($urandom_range(0, 1));
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    task automatic match_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got reason %0d",
                         $time, out_item.reason_code);
                errors++;
            end else begin
                report_want = expected_reports.pop_front();
                match_field("eligible", report_want.eligible, out_item.eligible);
                match_field("reason_code", report_want.reason_code, out_item.reason_code);
                match_field("first_row", report_want.first_row, out_item.first_row);
                match_field("span_rows", report_want.span_rows, out_item.span_rows);
                reports_checked++;
            end
            reasons_seen[out_item.reason_code] = 1'b1;
        end
    end

    // Watchdog: ends the run if no item, report or register write moves.
    initial begin
        int idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (psel && penable)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end
        $display("%0t: timeout, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Gating reasons, walked up one register at a time from reset.
    task automatic test_gating();
        send_item(finish_item());                       // disabled
        drain_block();
        reg_write(REG_MODE, 32'd1);
        send_item(finish_item());                       // contract
        drain_block();
        reg_write(REG_CONTRACT, 32'd1);
        send_item(query_item(32'sd0));                  // capacity still zero: empty
        send_item(page_item(32'd0, 32'd0, 16'(PAGE_ROWS), 32'd0));
        send_item(finish_item());
        drain_block();
        reg_write(REG_CAPACITY, 32'h000F_FFFF);         // widest window
        send_item(page_item(32'd0, 32'd0, 16'(PAGE_ROWS), 32'd0));
        send_item(finish_item());                       // no queries
    endtask

    // Per-page checks and their priority.
    task automatic test_page_rules();
        t_in_item it;
        drain_block();
        reg_write(REG_EXPECTED, 32'(2 * PAGE_ROWS + 16));
        // Dense span with a partial tail; logical page wraps through zero,
        // query positions at both extremes, an unused command in the middle.
        send_item(query_item(32'sh8000_0000));
        send_item(query_item(32'sh7FFF_FFFF));
        send_item(page_item(32'hFFFF_FFFF, 32'd0, 16'(PAGE_ROWS), 32'd0));
        it = random_item();
        it.command = CMD_UNUSED;
        send_item(it);
        send_item(page_item(32'd0, 32'd1, 16'(PAGE_ROWS), 32'(PAGE_ROWS)));
        send_item(page_item(32'd1, 32'd2, 16'd16, 32'(2 * PAGE_ROWS)));
        send_item(finish_item());
        // Query positions going backwards.
        send_item(query_item(32'sd7));
        send_item(query_item(32'sd6));
        send_item(page_item(32'd0, 32'd0, 16'(PAGE_ROWS), 32'd0));
        send_item(finish_item());
        // Oversized page first, then a gap: the first error sticks.
        send_item(query_item(32'sd0));
        it = page_item(32'd0, 32'd0, 16'hFFFF, 32'd0);
        it.native_end = 32'h7FFF_FFFF;
        send_item(it);
        send_item(page_item(32'd5, 32'd9, 16'(PAGE_ROWS), 32'(PAGE_ROWS)));
        send_item(finish_item());
        // Partial page followed by a bad page: partial is noted first.
        send_item(query_item(32'sd0));
        send_item(page_item(32'd0, 32'd0, 16'd10, 32'd0));
        send_item(page_item(32'd1, 32'd1, 16'(PAGE_ROWS), 32'hFFFF_FF00));
        send_item(finish_item());
        // Physical slot skips one.
        send_item(query_item(32'sd0));
        send_item(page_item(32'd0, 32'd0, 16'(PAGE_ROWS), 32'd0));
        send_item(page_item(32'd1, 32'd2, 16'(PAGE_ROWS), 32'(PAGE_ROWS)));
        send_item(finish_item());
    endtask

    // Pages pass at the capacity they met; the span is judged at finish
    // against the capacity written in between.
    task automatic test_capacity_midway();
        drain_block();
        reg_write(REG_CAPACITY, 32'd4);
        reg_write(REG_EXPECTED, 32'(2 * PAGE_ROWS));
        send_item(query_item(32'sd0));
        send_item(page_item(32'd0, 32'd2, 16'(PAGE_ROWS), 32'd0));
        send_item(page_item(32'd1, 32'd3, 16'(PAGE_ROWS), 32'(PAGE_ROWS)));
        drain_block();
        reg_write(REG_CAPACITY, 32'd3);
        send_item(finish_item());
    endtask

    // Long receiver hold-off while the sender keeps offering finishes,
    // so the result register fills and the input backs up.
    task automatic test_backpressure();
        drain_block();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (int k = 0; k < 24; k++) begin
            send_item((k % 3 == 0) ? query_item($urandom) : finish_item());
        end
        gaps_on = 1'b1;
    endtask

    task automatic retune_config();
        int          cap_pick;
        int          exp_pick;
        int          row_sum;
        logic [31:0] cap_value;
        logic [31:0] exp_value;
        plan_pages = $urandom_range(1, 6);
        plan_tail  = ($urandom_range(0, 1) == 0) ? PAGE_ROWS : $urandom_range(1, PAGE_ROWS);
        row_sum    = (plan_pages - 1) * PAGE_ROWS + plan_tail;
        cap_pick   = $urandom_range(0, 9);
        exp_pick   = $urandom_range(0, 9);
        case (cap_pick)
            0:       cap_value = 32'd0;
            1:       cap_value = 32'd1;
            2:       cap_value = 32'h000F_FFFF;
            3:       cap_value = $urandom;            // upper bits must be dropped
            default: cap_value = $urandom_range(8, 64);
        endcase
        case (exp_pick)
            0:       exp_value = 32'd0;
            1:       exp_value = 32'hFFFF_FFFF;
            2:       exp_value = $urandom;
            3:       exp_value = 32'(row_sum + 1);
            default: exp_value = 32'(row_sum);
        endcase
        drain_block();
        reg_write(REG_MODE, ($urandom & ~32'd1) | 32'($urandom_range(0, 9) != 0));
        reg_write(REG_CONTRACT, ($urandom & ~32'd1) | 32'($urandom_range(0, 9) != 0));
        reg_write(REG_CAPACITY, cap_value);
        reg_write(REG_EXPECTED, exp_value);
    endtask

    // One stream: queries, a run of pages, maybe a late query, a flaw, a stray item or both, a finish.
    task automatic run_random_span();
        t_in_item           seq[$];
        int                 n_q;
        int                 k;
        logic [31:0]        slot0;
        logic [31:0]        logical0;
        logic [31:0]        nb0;
        logic signed [31:0] pos;
        if ($urandom_range(0, 9) < 3) begin
            retune_config();
        end
        n_q = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
        pos = $urandom;
        for (int q = 0; q < n_q; q++) begin
            seq.push_back(query_item(pos));
            pos = pos + 32'($urandom_range(0, 3));
        end
        if (cfg.physical_page_capacity > plan_pages) begin
            slot0 = $urandom_range(0, 32'(cfg.physical_page_capacity) - plan_pages);
        end else begin
            slot0 = $urandom_range(0, 3);
        end
        logical0 = $urandom;
        nb0      = $urandom_range(0, 32'h007F_FFF0) << PAGE_SHIFT;
        for (int p = 0; p < plan_pages; p++) begin
            seq.push_back(page_item(logical0 + 32'(p), slot0 + 32'(p),
                                    16'((p == plan_pages - 1) ? plan_tail : PAGE_ROWS),
                                    nb0 + 32'(p * PAGE_ROWS)));
        end
        if (n_q > 0 && $urandom_range(0, 4) == 0) begin
            seq.push_back(query_item(pos));             // late query, still in order
        end
        if ($urandom_range(0, 9) < 3) begin
            k = n_q + $urandom_range(0, plan_pages - 1);
            case ($urandom_range(0, 7))
                0: if (n_q >= 2) seq[1].query_position = seq[0].query_position - 32'sd1;
                1: seq[k].page_rows = 16'($urandom);
                2: seq[k].physical_slot = $urandom;
                3: seq[k].native_begin = $urandom;
                4: seq[k].native_end = $urandom;
                5: seq[k].lpage_num = $urandom;
                6: if (plan_pages > 1) begin           // partial page mid-span
                    k = n_q + $urandom_range(0, plan_pages - 2);
                    seq[k].page_rows  = 16'($urandom_range(1, PAGE_ROWS - 1));
                    seq[k].native_end = seq[k].native_begin + 32'(seq[k].page_rows);
                end
                default: if (plan_pages > 2) seq.delete(n_q + 1);  // hole in the run
            endcase
        end
        if ($urandom_range(0, 4) == 0) begin
            seq.insert($urandom_range(0, seq.size()), random_item());
        end
        seq.push_back(finish_item());
        foreach (seq[i]) begin
            send_item(seq[i]);
        end
    endtask

    task automatic test_random_spans(input int target);
        int stop_at = items_sent + target;
        retune_config();
        while (items_sent < stop_at) begin
            run_random_span();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        span = span_cleared();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_gating();
        test_page_rules();
        test_capacity_midway();
        test_backpressure();
        test_random_spans(1150);

        drain_block();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d items, %0d reports, %0d register writes,",
                 items_sent, reports_checked, writes_done);
        $display("%0d long hold-off(s); reason codes reported, one bit per code: %b",
                 holds_done, reasons_seen);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
